// ===== rtl/core/scf_pkg.sv =====
// scf_pkg: shared types and constants of the strip cluster finder
// used by scf_ctrl, scf_dp and strip_cluster_finder_centroid
`timescale 1ns / 1ps

package scf_pkg;

  localparam int ChannelCountDefault = 1024;
  localparam int ChargeBitsDefault   = 12;

  localparam int ChW    = 10;
  localparam int QW     = 12;
  localparam int CntW   = 11;
  localparam int SumW   = 22;
  localparam int SwW    = 32;
  localparam int SqW    = 34;
  localparam int PeakW  = 13;
  localparam int ThrW   = 19;
  localparam int MaxWW  = 8;
  localparam int DivW   = 40;
  localparam int RootW  = 40;
  localparam int IterN  = 40;
  localparam int IterW  = 6;

  localparam int CenW   = 18;
  localparam int ErrW   = 17;
  localparam int HcW    = 7;
  localparam int CsW    = 19;

  localparam int InDataW  = 24;
  localparam int OutDataW = 72;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 19;

  localparam logic [CfgIdxW-1:0] RegThreshold = 1'd0;
  localparam logic [CfgIdxW-1:0] RegMaxWidth  = 1'd1;

  localparam logic [ThrW-1:0]  ThresholdReset = 19'd50;
  localparam logic [MaxWW-1:0] MaxWidthReset  = 8'd90;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_START_A,
    ST_RUN_A,
    ST_START_B,
    ST_RUN_B,
    ST_LOAD,
    ST_END
  } state_e;

  typedef struct packed {
    logic accept;
    logic eval;
    logic snap_end;
    logic start_a;
    logic step;
    logic start_b;
    logic load;
    logic final_flag;
  } cmd_t;

  typedef struct packed {
    logic emit_now;
    logic eos;
    logic end_kept;
    logic iter_last;
    logic out_busy;
  } sts_t;

endpackage

// ===== rtl/core/scf_ctrl.sv =====
// scf_ctrl: sequencing state machine of the strip cluster finder
// depends on scf_pkg; drives scf_dp through cmd_t, reads sts_t
`timescale 1ns / 1ps

module scf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  scf_pkg::sts_t sts_i,
  output scf_pkg::cmd_t cmd_o
);

  scf_pkg::state_e state_q, state_d;
  logic is_end_q, is_end_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= scf_pkg::ST_IDLE;
      is_end_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      is_end_q <= is_end_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    is_end_d   = is_end_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      scf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = scf_pkg::ST_EVAL;
        end
      end
      scf_pkg::ST_EVAL: begin
        cmd_o.eval = 1'b1;
        if (sts_i.emit_now) begin
          is_end_d = 1'b0;
          state_d  = scf_pkg::ST_START_A;
        end else begin
          state_d = scf_pkg::ST_END;
        end
      end
      scf_pkg::ST_START_A: begin
        cmd_o.start_a = 1'b1;
        state_d       = scf_pkg::ST_RUN_A;
      end
      scf_pkg::ST_RUN_A: begin
        cmd_o.step = 1'b1;
        if (sts_i.iter_last) state_d = scf_pkg::ST_START_B;
      end
      scf_pkg::ST_START_B: begin
        cmd_o.start_b = 1'b1;
        state_d       = scf_pkg::ST_RUN_B;
      end
      scf_pkg::ST_RUN_B: begin
        cmd_o.step = 1'b1;
        if (sts_i.iter_last) state_d = scf_pkg::ST_LOAD;
      end
      scf_pkg::ST_LOAD: begin
        if (!sts_i.out_busy) begin
          cmd_o.load       = 1'b1;
          // a split result is last only if the set end adds no cluster
          cmd_o.final_flag = is_end_q | (sts_i.eos & ~sts_i.end_kept);
          state_d          = is_end_q ? scf_pkg::ST_IDLE : scf_pkg::ST_END;
        end
      end
      scf_pkg::ST_END: begin
        if (sts_i.eos) begin
          cmd_o.snap_end = 1'b1;
          if (sts_i.end_kept) begin
            is_end_d = 1'b1;
            state_d  = scf_pkg::ST_START_A;
          end else begin
            state_d = scf_pkg::ST_IDLE;
          end
        end else begin
          state_d = scf_pkg::ST_IDLE;
        end
      end
      default: state_d = scf_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/scf_dp.sv =====
// scf_dp: cluster accumulators, radix-2 divider, digit square root, result register
// depends on scf_pkg; controlled by scf_ctrl
`timescale 1ns / 1ps

module scf_dp #(
  parameter int CHANNEL_COUNT = scf_pkg::ChannelCountDefault,
  parameter int CHARGE_BITS   = scf_pkg::ChargeBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [scf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [scf_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic [scf_pkg::ChW-1:0]      in_channel_i,
  input  logic [scf_pkg::QW-1:0]       in_charge_i,
  input  logic                         in_eos_i,
  input  scf_pkg::cmd_t                cmd_i,
  output scf_pkg::sts_t                sts_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [scf_pkg::ChW-1:0]      out_first_o,
  output logic [scf_pkg::HcW-1:0]      out_count_o,
  output logic [scf_pkg::CsW-1:0]      out_sum_o,
  output logic [scf_pkg::CenW-1:0]     out_cen_o,
  output logic [scf_pkg::ErrW-1:0]     out_err_o,
  output logic                         out_final_o
);

  localparam int QB = (CHARGE_BITS < scf_pkg::QW) ? CHARGE_BITS : scf_pkg::QW;
  localparam logic [scf_pkg::QW:0] QMaskWide = (13'd1 << QB) - 13'd1;
  localparam logic [scf_pkg::QW-1:0] QMask = QMaskWide[scf_pkg::QW-1:0];
  localparam logic [12:0] ChLimit = 13'(CHANNEL_COUNT);

  // configuration
  logic [scf_pkg::ThrW-1:0]  thr_q;
  logic [scf_pkg::MaxWW-1:0] maxw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= scf_pkg::ThresholdReset;
      maxw_q <= scf_pkg::MaxWidthReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == scf_pkg::RegThreshold) thr_q <= cfg_data_i;
      if (cfg_index_i == scf_pkg::RegMaxWidth) maxw_q <= cfg_data_i[scf_pkg::MaxWW-1:0];
    end
  end

  // latched input transaction
  logic [scf_pkg::ChW-1:0] ch_q;
  logic [scf_pkg::QW-1:0]  q_q;
  logic                    eos_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ch_q  <= in_channel_i;
      q_q   <= in_charge_i & QMask;
      eos_q <= in_eos_i;
    end
  end

  // cluster state
  logic                       hp_q;
  logic [scf_pkg::ChW-1:0]    pch_q, st_q, first_q;
  logic [scf_pkg::QW-1:0]     pq_q;
  logic [21:0]                pw_q;
  logic [23:0]                pqq_q;
  logic signed [scf_pkg::PeakW-1:0] peak_q;
  logic [scf_pkg::CntW-1:0]   cnt_q;
  logic [scf_pkg::SumW-1:0]   sum_q;
  logic [scf_pkg::SwW-1:0]    sw_q;
  logic [scf_pkg::SqW-1:0]    sq_q;

  logic [21:0] wprod;
  logic [23:0] qsq;
  logic hit_ok, contig, split, gap, cont, wcut, new_clu, kept_cur;
  logic signed [scf_pkg::PeakW-1:0] q_s, peak_max;
  logic [scf_pkg::ChW:0] span;

  assign wprod    = 22'(ch_q) * 22'(q_q);
  assign qsq      = 24'(q_q) * 24'(q_q);
  assign q_s      = $signed({1'b0, q_q});
  assign hit_ok   = {3'b000, ch_q} < ChLimit;
  assign contig   = hp_q && ({1'b0, ch_q} == ({1'b0, pch_q} + 11'd1));
  assign split    = contig && (q_q > pq_q) && ($signed({1'b0, pq_q}) < peak_q)
                    && (q_s != peak_q);
  assign gap      = hp_q && !contig;
  assign cont     = contig && !split;
  assign span     = {1'b0, pch_q} - {1'b0, st_q} + 11'd1;
  assign wcut     = cont && (pch_q >= st_q) && (span >= {3'b000, maxw_q});
  assign new_clu  = !hp_q || gap;
  assign peak_max = (q_s > peak_q) ? q_s : peak_q;
  assign kept_cur = (cnt_q != '0) && (sum_q > {3'b000, thr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q    <= 1'b0;
      pch_q   <= '0;
      pq_q    <= '0;
      st_q    <= '0;
      first_q <= '0;
      peak_q  <= '1;
      cnt_q   <= '0;
      sum_q   <= '0;
      sw_q    <= '0;
      sq_q    <= '0;
      pw_q    <= '0;
      pqq_q   <= '0;
    end else if (cmd_i.snap_end) begin
      hp_q    <= 1'b0;
      pch_q   <= '0;
      pq_q    <= '0;
      st_q    <= '0;
      first_q <= '0;
      peak_q  <= '1;
      cnt_q   <= '0;
      sum_q   <= '0;
      sw_q    <= '0;
      sq_q    <= '0;
    end else if (cmd_i.eval && hit_ok) begin
      hp_q  <= 1'b1;
      pch_q <= ch_q;
      pq_q  <= q_q;
      pw_q  <= wprod;
      pqq_q <= qsq;
      priority if (new_clu) begin
        cnt_q   <= 11'd1;
        sum_q   <= 22'(q_q);
        sw_q    <= 32'(wprod);
        sq_q    <= 34'(qsq);
        first_q <= ch_q;
        st_q    <= ch_q;
        peak_q  <= q_s;
      end else if (split) begin
        // the valley hit opens the new cluster
        cnt_q   <= 11'd2;
        sum_q   <= 22'(pq_q) + 22'(q_q);
        sw_q    <= 32'(pw_q) + 32'(wprod);
        sq_q    <= 34'(pqq_q) + 34'(qsq);
        first_q <= pch_q;
        st_q    <= ch_q;
        peak_q  <= q_s;
      end else if (wcut) begin
        cnt_q   <= 11'd1;
        sum_q   <= 22'(q_q);
        sw_q    <= 32'(wprod);
        sq_q    <= 34'(qsq);
        first_q <= ch_q;
        st_q    <= ch_q;
        peak_q  <= '1;
      end else begin
        cnt_q  <= cnt_q + 11'd1;
        sum_q  <= sum_q + 22'(q_q);
        sw_q   <= sw_q + 32'(wprod);
        sq_q   <= sq_q + 34'(qsq);
        peak_q <= peak_max;
      end
    end
  end

  // snapshot of the cluster being reported
  logic [scf_pkg::ChW-1:0]  sn_first_q;
  logic [scf_pkg::CntW-1:0] sn_cnt_q;
  logic [scf_pkg::SumW-1:0] sn_sum_q;
  logic [scf_pkg::SwW-1:0]  sn_sw_q;
  logic [scf_pkg::SqW-1:0]  sn_sq_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval || cmd_i.snap_end) begin
      sn_first_q <= first_q;
      sn_cnt_q   <= cnt_q;
      sn_sum_q   <= sum_q;
      sn_sw_q    <= sw_q;
      sn_sq_q    <= sq_q;
    end
  end

  // iteration counter shared by divider and root
  logic [scf_pkg::IterW-1:0] it_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it_q <= '0;
    end else if (cmd_i.start_a || cmd_i.start_b) begin
      it_q <= '0;
    end else if (cmd_i.step) begin
      it_q <= it_q + 6'd1;
    end
  end

  // restoring divider, one quotient bit per step
  logic [scf_pkg::SumW-1:0] drem_q;
  logic [scf_pkg::DivW-1:0] dquo_q;
  logic [scf_pkg::SumW:0]   drem_sh;
  logic                     dge;

  assign drem_sh = {drem_q, dquo_q[scf_pkg::DivW-1]};
  assign dge     = drem_sh >= {1'b0, sn_sum_q};

  // digit square root of sum q^2 scaled by 2^32
  logic [47:0]              rs_q;
  logic [42:0]              rrem_q;
  logic [scf_pkg::RootW-1:0] root_q;
  logic [44:0]              rrem_sh, rtrial;
  logic                     rge;

  assign rrem_sh = {rrem_q, rs_q[47:46]};
  assign rtrial  = {3'b000, root_q, 2'b01};
  assign rge     = rrem_sh >= rtrial;

  logic [scf_pkg::CenW-1:0] cen_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_a) begin
      drem_q <= '0;
      dquo_q <= {sn_sw_q, 8'd0};
      rs_q   <= {14'd0, sn_sq_q};
      rrem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.start_b) begin
      cen_q  <= (dquo_q > 40'h3FFFF) ? 18'h3FFFF : dquo_q[scf_pkg::CenW-1:0];
      drem_q <= '0;
      dquo_q <= root_q;
    end else if (cmd_i.step) begin
      if (dge) begin
        drem_q <= 22'(drem_sh - {1'b0, sn_sum_q});
        dquo_q <= {dquo_q[scf_pkg::DivW-2:0], 1'b1};
      end else begin
        drem_q <= drem_sh[scf_pkg::SumW-1:0];
        dquo_q <= {dquo_q[scf_pkg::DivW-2:0], 1'b0};
      end
      rs_q <= {rs_q[45:0], 2'b00};
      if (rge) begin
        rrem_q <= 43'(rrem_sh - rtrial);
        root_q <= {root_q[scf_pkg::RootW-2:0], 1'b1};
      end else begin
        rrem_q <= rrem_sh[42:0];
        root_q <= {root_q[scf_pkg::RootW-2:0], 1'b0};
      end
    end
  end

  // result register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_first_o <= sn_first_q;
      out_count_o <= (sn_cnt_q > 11'd127) ? 7'd127 : sn_cnt_q[scf_pkg::HcW-1:0];
      out_sum_o   <= (sn_sum_q > 22'h7FFFF) ? 19'h7FFFF : sn_sum_q[scf_pkg::CsW-1:0];
      out_cen_o   <= cen_q;
      out_err_o   <= (dquo_q > 40'h10000) ? 17'h10000 : dquo_q[scf_pkg::ErrW-1:0];
      out_final_o <= cmd_i.final_flag;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.emit_now  = hit_ok && (split || gap || wcut) && kept_cur;
  assign sts_o.eos       = eos_q;
  assign sts_o.end_kept  = kept_cur;
  assign sts_o.iter_last = it_q == 6'(scf_pkg::IterN - 1);
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

endmodule

// ===== rtl/core/strip_cluster_finder_centroid.sv =====
// strip_cluster_finder_centroid: top level, strip hits in, centroid clusters out
// depends on scf_pkg, scf_ctrl and scf_dp
`timescale 1ns / 1ps

// Usage:
//   Input stream: one strip hit per transaction, channels strictly rising within
//   a set; tlast marks the last hit of a sensor side.
//   Output stream: one cluster per transaction; tlast marks the last cluster
//   caused by a hit that carried tlast.
//   Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i
//   (0 charge threshold, 1 maximum width); write only while idle.
//   Timing: a hit that closes no cluster passes through accept, evaluate and
//   end check. Each reported cluster adds 40 steps of the shared restoring
//   divider, run beside 40 steps of the root unit, then 40 more divider steps
//   for the error term, plus setup and load.
//   The result sits in an output register, so the next hit is taken while it
//   waits; a stalled receiver only holds the block once a second result is
//   ready to load.
//   Reset: registers return to 50 and 90, cluster state is cleared, no output.
module strip_cluster_finder_centroid #(
  parameter int CHANNEL_COUNT = scf_pkg::ChannelCountDefault,
  parameter int CHARGE_BITS   = scf_pkg::ChargeBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [scf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [scf_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // channel[9:0], charge[21:10], zero[23:22]
  input  logic [scf_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // first_channel[9:0], hit_count[16:10], charge_sum[35:17],
  // centroid[53:36], centroid_error[70:54], zero[71]
  output logic [scf_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast
);

  scf_pkg::cmd_t cmd;
  scf_pkg::sts_t sts;

  logic [scf_pkg::ChW-1:0]  first_ch;
  logic [scf_pkg::HcW-1:0]  hit_cnt;
  logic [scf_pkg::CsW-1:0]  q_sum;
  logic [scf_pkg::CenW-1:0] cen;
  logic [scf_pkg::ErrW-1:0] err;

  scf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  scf_dp #(
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .CHARGE_BITS   (CHARGE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_channel_i (s_axis_tdata[9:0]),
    .in_charge_i  (s_axis_tdata[21:10]),
    .in_eos_i     (s_axis_tlast),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_first_o  (first_ch),
    .out_count_o  (hit_cnt),
    .out_sum_o    (q_sum),
    .out_cen_o    (cen),
    .out_err_o    (err),
    .out_final_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, err, cen, q_sum, hit_cnt, first_ch};

endmodule
